FILE: sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and sizing constants for the double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 8;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW         = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_READ_IDX   = 3'd4,
        REQ_WRITE_IDX  = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        t_req        req_type;
        logic [7:0]  value;
        logic [5:0]  position;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  data;
        t_status     status;
        logic [6:0]  count;
    } t_out_word;

endpackage

FILE: sv/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended byte queue kept in a ring buffer RAM.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (i_valid, i_in, o_stall) carries one word per request:
// push front or back, pop front or back, or read or write at a position
// counted from the front. The result channel (o_valid, o_out, i_stall)
// returns exactly one word per request with the data, a status and the count
// held after the request. Refused requests leave the queue untouched.
// o_valid rises in the cycle after acceptance. A request is taken every cycle
// while o_stall is low; the single RAM port serves each request in its accept
// cycle and the read data is registered into the result stage. Head and count
// live in registers, so no two requests contend for the same entry out of
// order. Reset empties the queue (head and count to zero); RAM contents are
// not cleared and need no clearing pass. While the receiver holds i_stall
// with a result pending, o_stall is raised and the pending result holds steady.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  deq_pkg::t_in_word  i_in,
    output logic               o_stall,
    output logic               o_valid,
    output deq_pkg::t_out_word o_out,
    input  logic               i_stall
);

    localparam int AW = deq_pkg::AW;
    localparam int CW = deq_pkg::CW;

    logic                          accept;
    logic [AW-1:0]                 r_head, n_head;
    logic [CW-1:0]                 r_fill, n_fill;
    logic                          r_vld;
    deq_pkg::t_status              r_status, n_status;
    logic                          r_is_rd, n_is_rd;
    logic                          mem_we, mem_re;
    logic [AW-1:0]                 offset, ring_addr, head_m1, mem_addr;
    logic [AW:0]                   ring_sum;
    logic [CW-1:0]                 fill_m1;
    logic                          is_full, is_empty, pos_bad;
    logic [deq_pkg::DATA_WIDTH-1:0] rd_data;

    assign accept  = i_valid & ~o_stall;
    assign o_stall = r_vld & i_stall;

    assign is_full  = (r_fill == CW'(deq_pkg::DEPTH));
    assign is_empty = (r_fill == '0);
    assign pos_bad  = ((CW+6)'(i_in.position) >= (CW+6)'(r_fill));
    assign fill_m1  = r_fill - CW'(1);
    assign head_m1  = (r_head == '0) ? AW'(deq_pkg::DEPTH - 1) : r_head - AW'(1);

    // Ring position of an offset from the head, wrapped once.
    assign ring_sum  = {1'b0, r_head} + {1'b0, offset};
    assign ring_addr = (ring_sum >= (AW+1)'(deq_pkg::DEPTH))
                       ? AW'(ring_sum - (AW+1)'(deq_pkg::DEPTH))
                       : AW'(ring_sum);

    always_comb begin
        n_head   = r_head;
        n_fill   = r_fill;
        n_status = deq_pkg::ST_OK;
        n_is_rd  = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        offset   = '0;
        mem_addr = ring_addr;
        unique case (i_in.req_type)
            deq_pkg::REQ_PUSH_FRONT: begin
                mem_addr = head_m1;
                if (is_full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    mem_we = 1'b1;
                    n_head = head_m1;
                    n_fill = r_fill + CW'(1);
                end
            end
            deq_pkg::REQ_PUSH_BACK: begin
                offset = AW'(r_fill);
                if (is_full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    mem_we = 1'b1;
                    n_fill = r_fill + CW'(1);
                end
            end
            deq_pkg::REQ_POP_FRONT: begin
                mem_addr = r_head;
                if (is_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    mem_re  = 1'b1;
                    n_is_rd = 1'b1;
                    n_head  = (r_head == AW'(deq_pkg::DEPTH - 1)) ? '0 : r_head + AW'(1);
                    n_fill  = fill_m1;
                end
            end
            deq_pkg::REQ_POP_BACK: begin
                offset = AW'(fill_m1);
                if (is_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    mem_re  = 1'b1;
                    n_is_rd = 1'b1;
                    n_fill  = fill_m1;
                end
            end
            deq_pkg::REQ_READ_IDX: begin
                offset = AW'(i_in.position);
                if (pos_bad) begin
                    n_status = deq_pkg::ST_RANGE;
                end else begin
                    mem_re  = 1'b1;
                    n_is_rd = 1'b1;
                end
            end
            deq_pkg::REQ_WRITE_IDX: begin
                offset = AW'(i_in.position);
                if (pos_bad) begin
                    n_status = deq_pkg::ST_RANGE;
                end else begin
                    mem_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    deq_ram #(
        .WIDTH (deq_pkg::DATA_WIDTH),
        .DEPTH (deq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept & mem_we),
        .i_re    (accept & mem_re),
        .i_addr  (mem_addr),
        .i_wdata (i_in.value),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
            r_vld  <= 1'b0;
        end else begin
            if (accept) begin
                r_head <= n_head;
                r_fill <= n_fill;
            end
            r_vld <= accept | (r_vld & i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_is_rd  <= n_is_rd;
        end
    end

    // The RAM read register only loads on accept, so it holds while stalled.
    assign o_valid      = r_vld;
    assign o_out.data   = r_is_rd ? rd_data : 8'd0;
    assign o_out.status = r_status;
    assign o_out.count  = 7'(r_fill);

endmodule

FILE: sv/deq_chk.sv
// ----------------------------------------------------------------------------
// deq_chk
// Port-level checks for the double-ended queue unit.
// ----------------------------------------------------------------------------
module deq_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input deq_pkg::t_in_word  i_in,
    input logic               o_stall,
    input logic               o_valid,
    input deq_pkg::t_out_word o_out,
    input logic               i_stall
);

    // Every accepted request produces a result word in the next cycle.
    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted request gave no result word");

    // A refused push can only be reported with the queue at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.status == deq_pkg::ST_FULL)
            |-> (o_out.count == 7'(deq_pkg::DEPTH)))
        else $error("full status with count below capacity");

    // A refused pop means nothing was held, and no data comes back.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.status == deq_pkg::ST_EMPTY)
            |-> (o_out.count == 7'd0 && o_out.data == 8'd0))
        else $error("empty status with nonzero count or data");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out)))
        else $error("stalled result word changed");

endmodule

bind double_ended_queue_unit deq_chk u_deq_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .i_in    (i_in),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_out   (o_out),
    .i_stall (i_stall)
);
